// ===== sv/md5v_pkg.sv =====
// Shared types, constants and round tables for the MD5 engine.
// Used by md5v_front, md5v_back and the top level; no dependencies.
package md5v_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] K28_STD = 32'h455a14ed;
    localparam logic [31:0] K28_VAR = 32'h445a14ed;
    localparam logic [5:0]  K28_ROUND = 6'd27;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LAST_POS = 6'h3f;
    localparam logic [5:0]  LEN_POS = 6'd56;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] S_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [1:0] {F_IDLE, F_PAD1, F_PAD2} t_fstate;
    typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_EMIT} t_bstate;

    // Block queue status from the front and control from the back.
    typedef struct packed {
        logic [1:0] full;
        logic [1:0] last;
    } t_q_stat;

    typedef struct packed {
        logic       pop;
        logic       sel;
        logic [3:0] idx;
    } t_q_ctl;

    // Message word used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [7:0] v;
        begin
            case (rnd[5:4])
                2'd0:    v = {2'b00, rnd};
                2'd1:    v = 8'd5 * {2'b00, rnd} + 8'd1;
                2'd2:    v = 8'd3 * {2'b00, rnd} + 8'd5;
                default: v = 8'd7 * {2'b00, rnd};
            endcase
            msg_index = v[3:0];
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        begin
            rot_amount = S_TAB[{rnd[5:4], rnd[1:0]}];
        end
    endfunction

endpackage

// ===== sv/md5v_front.sv =====
// Front end: packs request bytes into a two-slot block queue and pads.
// Depends on md5v_pkg.
module md5v_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_has_byte,
    input  logic               i_end_of_message,
    input  md5v_pkg::t_q_ctl   i_ctl,
    output md5v_pkg::t_q_stat  o_stat,
    output logic [31:0]        o_word
);

    logic [31:0]       r_buf [2][16];
    logic [1:0]        r_full, n_full;
    logic [1:0]        r_last, n_last;
    logic              r_wsel, n_wsel;
    logic [63:0]       r_bits, n_bits;
    md5v_pkg::t_fstate r_state, n_state;

    logic [5:0] pos;
    logic       slot_free;
    logic       acc;
    logic       take_byte;
    logic       pad_go;

    assign pos       = r_bits[8:3];
    assign slot_free = !r_full[r_wsel];
    assign o_stall   = (r_state != md5v_pkg::F_IDLE) || !slot_free;
    assign acc       = i_valid && !o_stall;
    assign take_byte = acc && i_has_byte;
    assign pad_go    = (r_state != md5v_pkg::F_IDLE) && slot_free;

    assign o_stat.full = r_full;
    assign o_stat.last = r_last;
    assign o_word      = r_buf[i_ctl.sel][i_ctl.idx];

    always_comb begin
        n_state = r_state;
        n_bits  = r_bits;
        n_full  = r_full;
        n_last  = r_last;
        n_wsel  = r_wsel;
        if (i_ctl.pop) begin
            n_full[i_ctl.sel] = 1'b0;
        end
        case (r_state)
            md5v_pkg::F_IDLE: begin
                if (acc) begin
                    if (i_has_byte) begin
                        n_bits = r_bits + 64'd8;
                        if (pos == md5v_pkg::LAST_POS) begin
                            n_full[r_wsel] = 1'b1;
                            n_last[r_wsel] = 1'b0;
                            n_wsel = !r_wsel;
                        end
                    end
                    if (i_end_of_message) begin
                        n_state = md5v_pkg::F_PAD1;
                    end
                end
            end
            md5v_pkg::F_PAD1: begin
                if (slot_free) begin
                    n_full[r_wsel] = 1'b1;
                    n_wsel = !r_wsel;
                    if (pos < md5v_pkg::LEN_POS) begin
                        n_last[r_wsel] = 1'b1;
                        n_bits = '0;
                        n_state = md5v_pkg::F_IDLE;
                    end else begin
                        n_last[r_wsel] = 1'b0;
                        n_state = md5v_pkg::F_PAD2;
                    end
                end
            end
            md5v_pkg::F_PAD2: begin
                if (slot_free) begin
                    n_full[r_wsel] = 1'b1;
                    n_last[r_wsel] = 1'b1;
                    n_wsel = !r_wsel;
                    n_bits = '0;
                    n_state = md5v_pkg::F_IDLE;
                end
            end
            default: n_state = md5v_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= md5v_pkg::F_IDLE;
            r_bits  <= '0;
            r_full  <= '0;
            r_last  <= '0;
            r_wsel  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_full  <= n_full;
            r_last  <= n_last;
            r_wsel  <= n_wsel;
        end
    end

    // Block data: byte writes while filling; at close, padding of the rest of the block and, if needed, a whole block.
    always_ff @(posedge i_clk) begin
        for (int w = 0; w < 16; w++) begin
            for (int l = 0; l < 4; l++) begin
                if (take_byte && pos == 6'(w * 4 + l)) begin
                    r_buf[r_wsel][w][l*8 +: 8] <= i_data_byte;
                end else if (pad_go && r_state == md5v_pkg::F_PAD1) begin
                    if (pos == 6'(w * 4 + l)) begin
                        r_buf[r_wsel][w][l*8 +: 8] <= md5v_pkg::PAD_BYTE;
                    end else if (6'(w * 4 + l) > pos) begin
                        r_buf[r_wsel][w][l*8 +: 8] <= 8'h00;
                    end
                end else if (pad_go && r_state == md5v_pkg::F_PAD2) begin
                    r_buf[r_wsel][w][l*8 +: 8] <= 8'h00;
                end
            end
        end
        // The bit length goes in the last two words of the final block.
        if (pad_go && (r_state == md5v_pkg::F_PAD2 || pos < md5v_pkg::LEN_POS)) begin
            r_buf[r_wsel][14] <= r_bits[31:0];
            r_buf[r_wsel][15] <= r_bits[63:32];
        end
    end

endmodule

// ===== sv/md5v_back.sv =====
// Back end: 64-round compression, one round per cycle, and digest output.
// Depends on md5v_pkg; reads blocks from the md5v_front queue.
module md5v_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_variant,
    input  md5v_pkg::t_q_stat  i_stat,
    input  logic [31:0]        i_word,
    output md5v_pkg::t_q_ctl   o_ctl,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_digest_word,
    output logic [1:0]         o_word_index,
    output logic               o_last_word
);

    md5v_pkg::t_bstate r_state, n_state;
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_rnd;
    logic        r_rsel;
    logic        r_var;
    logic [1:0]  r_oidx;

    logic [31:0] f, k, sum, nb;
    logic [63:0] dbl;

    always_comb begin
        case (r_rnd[5:4])
            2'd0:    f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1:    f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        if (r_rnd == md5v_pkg::K28_ROUND) begin
            k = r_var ? md5v_pkg::K28_VAR : md5v_pkg::K28_STD;
        end else begin
            k = md5v_pkg::K_TAB[r_rnd];
        end
        sum = r_a + f + k + i_word;
        dbl = {sum, sum} << md5v_pkg::rot_amount(r_rnd);
        nb  = r_b + dbl[63:32];
    end

    assign o_ctl.pop = (r_state == md5v_pkg::B_ADD);
    assign o_ctl.sel = r_rsel;
    assign o_ctl.idx = md5v_pkg::msg_index(r_rnd);

    assign o_valid       = (r_state == md5v_pkg::B_EMIT);
    assign o_digest_word = r_chain[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 2'd3);

    always_comb begin
        n_state = r_state;
        case (r_state)
            md5v_pkg::B_IDLE:  if (i_stat.full[r_rsel]) n_state = md5v_pkg::B_ROUND;
            md5v_pkg::B_ROUND: if (r_rnd == 6'd63) n_state = md5v_pkg::B_ADD;
            md5v_pkg::B_ADD: begin
                n_state = i_stat.last[r_rsel] ? md5v_pkg::B_EMIT : md5v_pkg::B_IDLE;
            end
            md5v_pkg::B_EMIT: begin
                if (!i_stall && r_oidx == 2'd3) n_state = md5v_pkg::B_IDLE;
            end
            default: n_state = md5v_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= md5v_pkg::B_IDLE;
            r_rnd      <= '0;
            r_rsel     <= 1'b0;
            r_var      <= 1'b0;
            r_oidx     <= '0;
            r_chain[0] <= md5v_pkg::IV_A;
            r_chain[1] <= md5v_pkg::IV_B;
            r_chain[2] <= md5v_pkg::IV_C;
            r_chain[3] <= md5v_pkg::IV_D;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_var <= i_cfg_variant;
            case (r_state)
                md5v_pkg::B_IDLE:  r_rnd <= '0;
                md5v_pkg::B_ROUND: r_rnd <= r_rnd + 6'd1;
                md5v_pkg::B_ADD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_rsel     <= !r_rsel;
                    r_oidx     <= '0;
                end
                md5v_pkg::B_EMIT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_chain[0] <= md5v_pkg::IV_A;
                            r_chain[1] <= md5v_pkg::IV_B;
                            r_chain[2] <= md5v_pkg::IV_C;
                            r_chain[3] <= md5v_pkg::IV_D;
                        end
                    end
                end
                default: r_rnd <= '0;
            endcase
        end
    end

    // Working variables of the round loop.
    always_ff @(posedge i_clk) begin
        if (r_state == md5v_pkg::B_IDLE) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (r_state == md5v_pkg::B_ROUND) begin
            r_a <= r_d;
            r_b <= nb;
            r_c <= r_b;
            r_d <= r_c;
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == md5v_pkg::B_ADD) |-> i_stat.full[r_rsel])
        else $error("block released from an empty slot");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == md5v_pkg::B_EMIT && i_stall) |=>
        (r_state == md5v_pkg::B_EMIT && $stable(r_oidx)))
        else $error("digest word lost while stalled");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == md5v_pkg::B_ROUND && r_rnd == 6'd63) |=> (r_state == md5v_pkg::B_ADD))
        else $error("compression did not finish after 64 rounds");
`endif

endmodule

// ===== sv/md5_hash_engine_with_variant.sv =====
// Top level of the MD5 engine: front end, block queue and compression back end.
// Depends on md5v_pkg, md5v_front and md5v_back.
//
// Usage:
// The input channel (i_valid / o_stall) takes one request per cycle while o_stall
// is low: an optional byte (i_has_byte) and an end-of-message flag. Bytes fill a
// 64-byte block in a two-slot queue; each full block is compressed by the back
// end, one round per cycle, then the chaining words are folded in (B_ADD) and the
// next block is loaded (B_IDLE). Sustained throughput is set by the single round
// unit; the front end fills the other slot meanwhile. A closing request builds
// the padded block(s) in F_PAD1, plus F_PAD2 when padding needs a second block,
// after which the back end compresses them and presents the four digest words
// A, B, C, D on o_valid / i_stall, one per cycle while i_stall is low, and
// o_last_word marks D.
// While the receiver stalls, the current digest word holds and the back end
// waits; the front end keeps filling until both queue slots are full.
// Reset (synchronous, active low) empties the queue, clears the bit count,
// loads the initial chaining words and sets the variant to standard MD5.
// i_cfg_we with i_cfg_variant selects the round-28 constant; write it only idle.
module md5_hash_engine_with_variant (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_variant,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    md5v_pkg::t_q_stat q_stat;
    md5v_pkg::t_q_ctl  q_ctl;
    logic [31:0]       q_word;

    md5v_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .i_ctl            (q_ctl),
        .o_stat           (q_stat),
        .o_word           (q_word)
    );

    md5v_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_variant (i_cfg_variant),
        .i_stat        (q_stat),
        .i_word        (q_word),
        .o_ctl         (q_ctl),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
